// ===== src/wrm_pkg.sv =====
// Types and constants for the windowed rate meter.
package wrm_pkg;

  localparam logic [1:0] OP_RECORD = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam int MS_PER_S = 1000;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] sample_count;
    logic [39:0] sample_time_ms;
    logic [15:0] window_seconds;
  } cmd_t;

  typedef struct packed {
    logic [63:0] rate_q8;
    logic        span_zero;
  } result_t;

  typedef struct packed {
    logic [31:0] count;
    logic [39:0] time_ms;
  } slot_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAST,
    ST_OLD,
    ST_SUM,
    ST_WALK,
    ST_WSPAN,
    ST_MUL,
    ST_DIV
  } state_t;

endpackage

// ===== src/windowed_rate_meter.sv =====
// Sliding-window rate meter over a ring of timestamped work-count samples.
//
// Commands: a transfer happens when start is high and busy is low; cmd carries
// op, sample_count, sample_time_ms and window_seconds.
// Record and clear produce no result and leave busy low.
// A query produces one result on the result port, flagged by done for
// exactly one cycle; the receiver cannot stall it and must take it then.
// Query: an empty ring gives a zero rate with span_zero set. Otherwise
// setup reads the newest and oldest samples, then every live sample is
// summed for the whole span or a window is walked back from the newest,
// the sum is scaled, and a DW = 50 + clog2(SLOTS) bit restoring divider
// yields one quotient bit per cycle; busy is high until the result shows.
// Samples live in one synchronous RAM of SLOTS entries; at most SLOTS-1
// samples are live. Reset and clear only reset the ring pointers, so no
// clearing pass over the RAM is needed.
module windowed_rate_meter
  import wrm_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  cmd_t    cmd,
  output logic    busy,
  output logic    done,
  output result_t result
);

  localparam int PW   = $clog2(SLOTS);
  localparam int SUMW = 32 + PW;
  localparam int DW   = SUMW + 18;
  localparam int CW   = $clog2(DW + 1);

  state_t state, state_next;

  slot_t mem [SLOTS];
  slot_t rdata;
  logic [PW-1:0] raddr;
  logic we;

  logic [PW-1:0] newest, oldest, idx, last;
  logic [39:0] t_last;
  logic [40:0] thr, span, full_c, span_c, rem_sh;
  logic [SUMW-1:0] sum;
  logic [SUMW+9:0] prod;
  logic [DW-1:0] dvd;
  logic [39:0] rem;
  logic [CW-1:0] cnt;
  logic accept, empty, walk_c, cont_c, span_ok, qbit;

  function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
    return (p == PW'(SLOTS - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PW-1:0] prv(input logic [PW-1:0] p);
    return (p == '0) ? PW'(SLOTS - 1) : p - 1'b1;
  endfunction

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  assign empty   = (newest == oldest);
  assign last    = prv(newest);
  assign full_c  = {1'b0, t_last} - {1'b0, rdata.time_ms};
  assign span_c  = full_c;
  assign walk_c  = (thr != '0) && !full_c[40] && (full_c >= thr);
  assign cont_c  = ($signed(span_c) < $signed(thr)) && (idx != oldest);
  assign span_ok = !span[40] && (span != '0);
  assign prod    = ({sum, 10'b0} - {6'b0, sum, 4'b0}) - {7'b0, sum, 3'b0};
  assign rem_sh  = {rem, dvd[DW-1]};
  assign qbit    = (rem_sh >= {1'b0, span[39:0]});
  assign we      = accept && (cmd.op == OP_RECORD);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept && cmd.op == OP_QUERY && !empty) state_next = ST_LAST;
      ST_LAST:  state_next = ST_OLD;
      ST_OLD:   state_next = walk_c ? ST_WALK : ST_SUM;
      ST_SUM:   if (idx == last) state_next = ST_MUL;
      ST_WALK:  state_next = ST_WSPAN;
      ST_WSPAN: state_next = cont_c ? ST_WALK : ST_MUL;
      ST_MUL:   state_next = span_ok ? ST_DIV : ST_IDLE;
      ST_DIV:   if (cnt == CW'(1)) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    unique case (state)
      ST_IDLE:  raddr = last;
      ST_LAST:  raddr = oldest;
      ST_OLD:   raddr = walk_c ? last : oldest;
      ST_SUM:   raddr = nxt(idx);
      ST_WALK:  raddr = prv(idx);
      default:  raddr = idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[newest] <= '{count: cmd.sample_count, time_ms: cmd.sample_time_ms};
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      newest <= '0;
      oldest <= '0;
      done   <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (cmd.op)
              OP_RECORD: begin
                newest <= nxt(newest);
                if (nxt(newest) == oldest) oldest <= nxt(oldest);
              end
              OP_CLEAR: begin
                newest <= '0;
                oldest <= '0;
              end
              OP_QUERY: begin
                thr <= 41'(cmd.window_seconds) * 41'(MS_PER_S);
                sum <= '0;
                if (empty) begin
                  done   <= 1'b1;
                  result <= '{rate_q8: '0, span_zero: 1'b1};
                end
              end
              default: ;
            endcase
          end
        end
        ST_LAST: t_last <= rdata.time_ms;
        ST_OLD: begin
          span <= full_c;
          idx  <= walk_c ? last : oldest;
        end
        ST_SUM: begin
          sum <= sum + SUMW'(rdata.count);
          idx <= nxt(idx);
        end
        ST_WALK: begin
          sum <= sum + SUMW'(rdata.count);
          idx <= prv(idx);
        end
        ST_WSPAN: span <= span_c;
        ST_MUL: begin
          if (!span_ok) begin
            done   <= 1'b1;
            result <= '{rate_q8: '0, span_zero: 1'b1};
          end
          dvd <= {prod, 8'b0};
          rem <= '0;
          cnt <= CW'(DW);
        end
        ST_DIV: begin
          rem <= qbit ? 40'(rem_sh - {1'b0, span[39:0]}) : rem_sh[39:0];
          dvd <= {dvd[DW-2:0], qbit};
          cnt <= cnt - 1'b1;
          if (cnt == CW'(1)) begin
            done   <= 1'b1;
            result <= '{rate_q8: 64'({dvd[DW-2:0], qbit}), span_zero: 1'b0};
          end
        end
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_ring_nonempty: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.op == OP_RECORD) |=> (newest != oldest))
    else $error("ring empty after record");
  a_div_span: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (!span[40] && span != '0))
    else $error("divider running with non-positive span");
  a_zero_rate: assert property (@(posedge clk) disable iff (rst)
    (done && result.span_zero) |-> (result.rate_q8 == '0))
    else $error("nonzero rate with span_zero");
  a_busy_query: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && accept && cmd.op == OP_QUERY && !empty) |=> busy)
    else $error("query not started");
`endif

endmodule

// ===== tb/sv/wrm_checker.sv =====
// Checker for the windowed rate meter: predicts query results and compares them.
module wrm_checker
  import wrm_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic         busy,
  input  cmd_t         cmd,
  input  logic         done,
  input  result_t      result,
  output int unsigned  fail_count,
  output int unsigned  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING = 16;

  logic [31:0] ring_count [RING];
  logic [39:0] ring_time  [RING];
  bit          ring_live  [RING];
  logic [3:0]  head_idx;
  logic [3:0]  tail_idx;
  result_t     rate_queue [$];

  function automatic void clear_ring();
    for (int i = 0; i < RING; i++) begin
      ring_count[i] = '0;
      ring_time[i]  = '0;
      ring_live[i]  = 1'b0;
    end
    head_idx = '0;
    tail_idx = '0;
  endfunction

  function automatic result_t rate_over_window(input logic [15:0] window_s);
    result_t r;
    logic [3:0] last_idx;
    logic [3:0] cur;
    longint full_ms;
    longint span;
    longint secs;
    longint unsigned total;
    r.rate_q8   = '0;
    r.span_zero = 1'b1;
    last_idx = head_idx - 4'd1;
    secs = longint'(window_s);
    total = 0;
    span = 0;
    if (!ring_live[tail_idx]) return r;
    full_ms = longint'(ring_time[last_idx]) - longint'(ring_time[tail_idx]);
    if (secs == 0 || full_ms / MS_PER_S < secs) begin
      cur = tail_idx;
      for (int k = 0; k < RING; k++) begin
        total += ring_count[cur];
        if (cur == last_idx) break;
        cur = cur + 4'd1;
      end
      span = full_ms;
    end else begin
      cur = last_idx;
      for (int k = 0; k < RING; k++) begin
        total += ring_count[cur];
        cur = cur - 4'd1;
        span = longint'(ring_time[last_idx]) - longint'(ring_time[cur]);
        if (!(span < secs * MS_PER_S && cur != tail_idx)) break;
      end
    end
    if (span <= 0) return r;
    if (total > 64'hFFFF_FFFF_FFFF_FFFF / 256000) r.rate_q8 = '1;
    else r.rate_q8 = (total * 256000) / longint'(span);
    r.span_zero = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    int unsigned errs;
    errs = 0;
    if (rst) begin
      clear_ring();
      rate_queue.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (done) begin
        if (rate_queue.size() == 0) begin
          $error("unexpected result transfer: rate_q8=%0h span_zero=%0b",
                 result.rate_q8, result.span_zero);
          errs++;
        end else begin
          want = rate_queue.pop_front();
          if (result.rate_q8 !== want.rate_q8) begin
            $error("rate_q8 expected %0h actual %0h", want.rate_q8, result.rate_q8);
            errs++;
          end
          if (result.span_zero !== want.span_zero) begin
            $error("span_zero expected %0b actual %0b", want.span_zero, result.span_zero);
            errs++;
          end
        end
      end
      if (start && !busy) begin
        case (cmd.op)
          OP_RECORD: begin
            ring_count[head_idx] = cmd.sample_count;
            ring_time[head_idx]  = cmd.sample_time_ms;
            ring_live[head_idx]  = 1'b1;
            head_idx = head_idx + 4'd1;
            if (head_idx == tail_idx) tail_idx = tail_idx + 4'd1;
          end
          OP_QUERY: rate_queue.push_back(rate_over_window(cmd.window_seconds));
          OP_CLEAR: clear_ring();
          default: ;
        endcase
      end
      fail_count <= fail_count + errs;
      pending    <= rate_queue.size();
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the windowed rate meter testbench: clock, reset, stimulus and verdict.
module testbench;
  import wrm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  cmd_t        cmd = '0;
  logic        busy;
  logic        done;
  result_t     result;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned idle_pct;
  int unsigned quiet_cycles = 0;
  logic [39:0] clock_ms;

  always #5 clk = ~clk;

  windowed_rate_meter DUT (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd),
    .busy(busy), .done(done), .result(result)
  );

  wrm_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .done(done), .result(result), .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic issue(input logic [1:0] op, input logic [31:0] count,
                       input logic [39:0] stamp, input logic [15:0] window_s);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    cmd.op = op;
    cmd.sample_count = count;
    cmd.sample_time_ms = stamp;
    cmd.window_seconds = window_s;
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    start = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_count();
    if ($urandom_range(3) == 0) return $urandom;
    return $urandom_range(5000);
  endfunction

  task automatic random_traffic(input int n);
    int unsigned sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 55) begin
        if ($urandom_range(19) == 0) clock_ms = {$urandom, 8'($urandom)};
        else if ($urandom_range(29) == 0) clock_ms = clock_ms - $urandom_range(2000);
        else clock_ms = clock_ms + $urandom_range(3000);
        issue(OP_RECORD, pick_count(), clock_ms, 16'($urandom));
      end else if (sel < 94) begin
        case ($urandom_range(3))
          0: issue(OP_QUERY, $urandom, {$urandom, 8'($urandom)}, '0);
          1: issue(OP_QUERY, $urandom, {$urandom, 8'($urandom)}, 16'($urandom));
          default: issue(OP_QUERY, $urandom, {$urandom, 8'($urandom)},
                         16'($urandom_range(40)));
        endcase
      end else if (sel < 97) begin
        issue(OP_CLEAR, $urandom, {$urandom, 8'($urandom)}, 16'($urandom));
      end else begin
        issue(2'd3, $urandom, {$urandom, 8'($urandom)}, 16'($urandom));
      end
    end
  endtask

  initial begin
    idle_pct = 0;
    clock_ms = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    issue(OP_QUERY, '0, '0, '0);
    issue(OP_RECORD, '1, '0, '0);
    issue(OP_QUERY, '0, '0, '0);
    issue(OP_RECORD, '1, '1, '0);
    issue(OP_QUERY, '0, '0, '0);
    issue(OP_QUERY, '0, '0, '1);
    issue(OP_RECORD, 32'd7, 40'd5, '0);
    issue(OP_QUERY, '0, '0, 16'd1);
    issue(OP_CLEAR, '1, '1, '1);
    issue(OP_QUERY, '0, '0, '0);
    issue(2'd3, 32'd9, 40'd100, 16'd1);
    issue(OP_QUERY, '0, '0, '0);
    for (int i = 0; i < 18; i++) begin
      clock_ms = clock_ms + 40'd1500;
      issue(OP_RECORD, 32'hFFFF_FFFF - i, clock_ms, '0);
    end
    issue(OP_QUERY, '0, '0, 16'd4);
    issue(OP_QUERY, '0, '0, 16'd3);
    issue(OP_QUERY, '0, '0, '0);
    issue(OP_RECORD, 32'd1, clock_ms, '0);
    issue(OP_QUERY, '0, '0, 16'd1);
    drain();

    idle_pct = 0;   random_traffic(350); drain();
    idle_pct = 77;  random_traffic(300); drain();
    idle_pct = 35;  random_traffic(350); drain();
    idle_pct = 0;   random_traffic(320);

    drain();
    repeat (150) @(posedge clk);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== files.f =====
src/wrm_pkg.sv
src/windowed_rate_meter.sv
tb/sv/wrm_checker.sv
tb/sv/testbench.sv
